### hw/rtl/fskf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fskf_pkg
// Shared types and constants for the first-seen key filter.
// ----------------------------------------------------------------------------
package fskf_pkg;

    // Default sizing of the hash set
    localparam int FSKF_BUCKET_COUNT   = 16384;
    localparam int FSKF_ENTRY_CAPACITY = 8192;
    localparam int FSKF_KEY_BITS       = 32;

    // Fixed field widths of the stream requests
    localparam int FSKF_KEY_W    = 32;
    localparam int FSKF_POS_W    = 13;
    localparam int FSKF_UCNT_W   = 14;
    localparam int FSKF_IDATA_W  = 32;
    localparam int FSKF_ODATA_W  = 64;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,   // sweeping the bucket heads to empty after reset
        ST_IDLE,    // waiting for a key
        ST_HREAD,   // bucket head read issued
        ST_HEAD,    // bucket head visible, first chain decision
        ST_CMP      // chain entry visible, compare and step
    } t_fskf_state;

endpackage : fskf_pkg
`default_nettype wire

### hw/rtl/fskf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fskf_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module fskf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire              i_clk,
    input  wire              i_we,
    input  wire [AW-1:0]     i_waddr,
    input  wire [WIDTH-1:0]  i_wdata,
    input  wire              i_re,
    input  wire [AW-1:0]     i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule : fskf_ram
`default_nettype wire

### hw/rtl/first_seen_key_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_seen_key_filter
// Chained hash set that flags the first appearance of each key in a stream.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one signed key per request on i_s_axis_tdata.
//   Master stream: one result per key: echo, new flag, position, full flag
//   and the running count of distinct keys.
//   The bucket is the low bits of the key magnitude (most negative key goes to
//   bucket 0). The chain of that bucket is walked one entry per cycle through
//   the entry RAM read port; a new key is linked in at the chain head.
//   Accept to result valid: head RAM read, head decision, then one compare
//   per chain entry; the result waits while the result register is full.
//   A key is taken only after the last key's result is loaded: the next key
//   is taken the cycle after, while the result register may still wait.
//   Reset: after i_rst_n is released the block clears every bucket head, one
//   per cycle, with o_s_axis_tready low meanwhile.
//   Receiver stall: the result register holds; a key whose result is ready
//   waits in the sequencer until the register frees up.
// ----------------------------------------------------------------------------
module first_seen_key_filter
    import fskf_pkg::*;
#(
    parameter int BUCKET_COUNT   = FSKF_BUCKET_COUNT,
    parameter int ENTRY_CAPACITY = FSKF_ENTRY_CAPACITY,
    parameter int KEY_BITS       = FSKF_KEY_BITS
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // key [31:0]
    input  wire [FSKF_IDATA_W-1:0]  i_s_axis_tdata,
    input  wire                     i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // key_out [31:0], is_new [32], position [45:33], store_full [46],
    // unique_count [60:47], zero [63:61]
    output logic [FSKF_ODATA_W-1:0] o_m_axis_tdata,
    output logic                    o_m_axis_tvalid,
    input  wire                     i_m_axis_tready
);

    localparam int BW = $clog2(BUCKET_COUNT);
    localparam int EW = (ENTRY_CAPACITY > 1) ? $clog2(ENTRY_CAPACITY) : 1;
    localparam int CW = $clog2(ENTRY_CAPACITY + 1);
    localparam int MW = (KEY_BITS > BW) ? KEY_BITS : BW;
    localparam int XW = KEY_BITS + CW;

    localparam logic [KEY_BITS-1:0] KEY_SIGN = {1'b1, {(KEY_BITS-1){1'b0}}};
    localparam logic [CW-1:0]       CAP      = CW'(ENTRY_CAPACITY);
    localparam logic [BW-1:0]       LAST_BKT = BW'(BUCKET_COUNT - 1);

    // Control and payload registers
    t_fskf_state             r_state, n_state;
    logic [BW-1:0]           r_clr_addr, n_clr_addr;
    logic [FSKF_KEY_W-1:0]   r_in_data, n_in_data;
    logic [BW-1:0]           r_bucket, n_bucket;
    logic [CW-1:0]           r_head, n_head;
    logic [CW-1:0]           r_steps, n_steps;
    logic [CW-1:0]           r_count, n_count;
    logic                    r_out_valid, n_out_valid;
    logic [FSKF_KEY_W-1:0]   r_out_key, n_out_key;
    logic                    r_out_new, n_out_new;
    logic [FSKF_POS_W-1:0]   r_out_pos, n_out_pos;
    logic                    r_out_full, n_out_full;
    logic [FSKF_UCNT_W-1:0]  r_out_ucnt, n_out_ucnt;

    // RAM ports
    logic                    head_we, head_re;
    logic [BW-1:0]           head_waddr;
    logic [CW-1:0]           head_wdata, head_rdata;
    logic                    ent_we, ent_re;
    logic [EW-1:0]           ent_waddr, ent_raddr;
    logic [XW-1:0]           ent_wdata, ent_rdata;

    // Datapath helpers
    logic [KEY_BITS-1:0]     w_key_in, w_mag, w_key;
    logic [BW-1:0]           w_bucket;
    logic [KEY_BITS-1:0]     ent_key;
    logic [CW-1:0]           ent_link;
    logic [CW-1:0]           cand_link, cand_steps, cur_head;
    logic                    found, walk_on, out_free;

    // Bucket of the incoming key: low bits of its magnitude
    always_comb begin
        w_key_in = KEY_BITS'($signed(i_s_axis_tdata));
        if (w_key_in == KEY_SIGN) begin
            w_mag = '0;
        end else if (w_key_in[KEY_BITS-1]) begin
            w_mag = KEY_BITS'(0) - w_key_in;
        end else begin
            w_mag = w_key_in;
        end
        w_bucket = BW'(MW'(w_mag) & MW'(BUCKET_COUNT - 1));
    end

    assign w_key    = KEY_BITS'($signed(r_in_data));
    assign ent_key  = ent_rdata[KEY_BITS-1:0];
    assign ent_link = ent_rdata[XW-1:KEY_BITS];
    assign out_free = !r_out_valid || i_m_axis_tready;

    // Bucket heads: 0 is an empty bucket, else entry index + 1
    fskf_ram #(
        .WIDTH (CW),
        .DEPTH (BUCKET_COUNT)
    ) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (head_waddr),
        .i_wdata (head_wdata),
        .i_re    (head_re),
        .i_raddr (r_bucket),
        .o_rdata (head_rdata)
    );

    // Entries: {link, key}, link is next index + 1 with 0 ending the chain
    fskf_ram #(
        .WIDTH (XW),
        .DEPTH (ENTRY_CAPACITY)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_re    (ent_re),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    // State register and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_in_data  <= n_in_data;
        r_bucket   <= n_bucket;
        r_head     <= n_head;
        r_steps    <= n_steps;
        r_out_key  <= n_out_key;
        r_out_new  <= n_out_new;
        r_out_pos  <= n_out_pos;
        r_out_full <= n_out_full;
        r_out_ucnt <= n_out_ucnt;
    end

    // Sequencer: clear sweep, head read, chain walk, insert and result
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_in_data   = r_in_data;
        n_bucket    = r_bucket;
        n_head      = r_head;
        n_steps     = r_steps;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out_key   = r_out_key;
        n_out_new   = r_out_new;
        n_out_pos   = r_out_pos;
        n_out_full  = r_out_full;
        n_out_ucnt  = r_out_ucnt;

        head_we    = 1'b0;
        head_re    = 1'b0;
        head_waddr = r_clr_addr;
        head_wdata = '0;
        ent_we     = 1'b0;
        ent_re     = 1'b0;
        ent_waddr  = EW'(r_count);
        ent_wdata  = '0;

        // Candidate for the next chain step
        found      = (r_state == ST_CMP) && (ent_key == w_key);
        cand_link  = (r_state == ST_HEAD) ? head_rdata : ent_link;
        cand_steps = (r_state == ST_HEAD) ? '0 : (r_steps + CW'(1));
        cur_head   = (r_state == ST_HEAD) ? head_rdata : r_head;
        walk_on    = !found && (cand_link != '0) && (cand_link <= CAP)
                     && (cand_steps < r_count);
        ent_raddr  = EW'(cand_link - CW'(1));

        // Result taken by the receiver
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                head_we    = 1'b1;
                n_clr_addr = r_clr_addr + BW'(1);
                if (r_clr_addr == LAST_BKT) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_in_data = i_s_axis_tdata;
                    n_bucket  = w_bucket;
                    n_state   = ST_HREAD;
                end
            end
            ST_HREAD: begin
                head_re = 1'b1;
                n_state = ST_HEAD;
            end
            ST_HEAD, ST_CMP: begin
                n_head = cur_head;
                if (walk_on) begin
                    ent_re  = 1'b1;
                    n_steps = cand_steps;
                    n_state = ST_CMP;
                end else if (out_free) begin
                    // Resolve: seen, dropped or inserted at the chain head
                    n_out_valid = 1'b1;
                    n_out_key   = r_in_data;
                    n_out_new   = 1'b0;
                    n_out_pos   = '0;
                    n_out_full  = 1'b0;
                    if (!found) begin
                        if (r_count >= CAP) begin
                            n_out_full = 1'b1;
                        end else begin
                            ent_we     = 1'b1;
                            ent_wdata  = {cur_head, w_key};
                            head_we    = 1'b1;
                            head_waddr = r_bucket;
                            head_wdata = r_count + CW'(1);
                            n_count    = r_count + CW'(1);
                            n_out_new  = 1'b1;
                            n_out_pos  = FSKF_POS_W'(r_count);
                        end
                    end
                    n_out_ucnt = FSKF_UCNT_W'(n_count);
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Stream ports
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_ucnt, r_out_full, r_out_pos,
                              r_out_new, r_out_key};

`ifndef NO_ASSERTIONS
    // Stored count never passes the capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP)
        else $error("entry count above capacity");

    // An insert after the clear sweep bumps the count by one
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (head_we && (r_state != ST_CLEAR)) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not advance the count");

    // A result is never both new and dropped
    a_new_xor_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_new && r_out_full))
        else $error("result both new and dropped");

    // Chain reads only follow a live link
    a_walk_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ent_re |-> ((cand_link != '0) && (cand_link <= CAP)))
        else $error("entry read through an empty link");

    // The entry RAM is never written during the clear sweep
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !ent_we)
        else $error("entry write during bucket clear");
`endif

endmodule : first_seen_key_filter
`default_nettype wire

### tb/sv/first_seen_key_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_seen_key_filter_tb
// Self-checking bench for the first-seen key filter. A bucket-chain model
// of the hash set runs alongside the block and predicts each untyped result. The
// stimulus runs in four parts. A short directed table comes first: bucket 0
// collisions, the most negative key, magnitude twins and repeats. Then about
// 1800 random keys that favor repeats and bucket collisions. Then fresh keys
// until the store is full, and a tail of keys against the full store. Both
// stream sides idle at random. One long receiver stall and one sender drain
// pause are included.
// ----------------------------------------------------------------------------
module first_seen_key_filter_tb;
    import fskf_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_KEYS  = 1800;
    localparam int AFTER_FULL   = 80;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 32;
    localparam int STALL_LIMIT  = 60000;

    localparam logic [FSKF_KEY_W-1:0] KEY_MIN = 32'h8000_0000;

    // One result request, with the fields of o_m_axis_tdata but not its bit layout
    typedef struct packed {
        logic [FSKF_KEY_W-1:0]  key_out;
        logic                   is_new;
        logic [FSKF_POS_W-1:0]  position;
        logic                   store_full;
        logic [FSKF_UCNT_W-1:0] unique_count;
    } t_lookup;

    // Directed row: typed rows carry their own expected result
    typedef struct packed {
        logic [FSKF_KEY_W-1:0]  key;
        logic                   typed;
        logic                   is_new;
        logic [FSKF_POS_W-1:0]  position;
        logic [FSKF_UCNT_W-1:0] unique_count;
    } t_probe_row;

    localparam int PROBE_COUNT = 20;
    localparam t_probe_row PROBE_ROWS [PROBE_COUNT] = '{
        '{32'h0000_0000, 1'b1, 1'b1, 13'd0, 14'd1},  // first key after reset
        '{32'h0000_0000, 1'b1, 1'b0, 13'd0, 14'd1},  // immediate repeat
        '{32'h8000_0000, 1'b1, 1'b1, 13'd1, 14'd2},  // most negative, bucket 0
        '{32'h7FFF_FFFF, 1'b1, 1'b1, 13'd2, 14'd3},  // most positive
        '{32'h0000_4000, 1'b1, 1'b1, 13'd3, 14'd4},  // bucket 0 again
        '{32'h8000_0000, 1'b0, 1'b0, 13'd0, 14'd0},  // found one link down
        '{32'hFFFF_FFFF, 1'b0, 1'b0, 13'd0, 14'd0},
        '{32'h0000_0001, 1'b0, 1'b0, 13'd0, 14'd0},  // magnitude twin of -1
        '{32'hFFFF_FFFF, 1'b0, 1'b0, 13'd0, 14'd0},
        '{32'hFFFF_C000, 1'b0, 1'b0, 13'd0, 14'd0},
        '{32'h0000_0000, 1'b0, 1'b0, 13'd0, 14'd0},  // tail of a long chain
        '{32'h8000_0001, 1'b0, 1'b0, 13'd0, 14'd0},  // shares bucket with max
        '{32'h7FFF_FFFF, 1'b0, 1'b0, 13'd0, 14'd0},
        '{32'h5555_5555, 1'b0, 1'b0, 13'd0, 14'd0},
        '{32'hAAAA_AAAA, 1'b0, 1'b0, 13'd0, 14'd0},
        '{32'h5555_5555, 1'b0, 1'b0, 13'd0, 14'd0},
        '{32'h0000_8000, 1'b0, 1'b0, 13'd0, 14'd0},
        '{32'hFFFF_C000, 1'b0, 1'b0, 13'd0, 14'd0},
        '{32'h0000_C000, 1'b0, 1'b0, 13'd0, 14'd0},
        '{32'h8000_0000, 1'b0, 1'b0, 13'd0, 14'd0}
    };

    localparam logic [FSKF_KEY_W-1:0] EDGE_KEYS [8] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
        32'h7FFF_FFFF, 32'h8000_0001, 32'h0000_4000, 32'hFFFF_C000
    };

    logic                    i_clk           = 1'b0;
    logic                    i_rst_n         = 1'b0;
    logic [FSKF_IDATA_W-1:0] i_s_axis_tdata  = '0;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    logic [FSKF_ODATA_W-1:0] o_m_axis_tdata;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;

    // Shadow hash set: chain links are entry index + 1, 0 ends a chain
    int unsigned             chain_head  [FSKF_BUCKET_COUNT];
    logic [FSKF_KEY_W-1:0]   stored_key  [FSKF_ENTRY_CAPACITY];
    int unsigned             stored_link [FSKF_ENTRY_CAPACITY];
    int unsigned             keys_stored = 0;

    t_lookup                 pending_results [$];
    logic [FSKF_KEY_W-1:0]   sent_keys [$];
    int unsigned             keys_sent   = 0;
    bit                      send_quiet  = 1'b0;
    int unsigned             mismatches  = 0;

    first_seen_key_filter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),   // key [31:0]
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // key_out, is_new, position,
        .o_m_axis_tvalid (o_m_axis_tvalid),  // store_full, unique_count, pad
        .i_m_axis_tready (i_m_axis_tready)
    );

    initial begin : clock_gen
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Bucket from the low bits of the key magnitude
    function automatic int unsigned bucket_index(input logic [FSKF_KEY_W-1:0] k);
        logic [FSKF_KEY_W-1:0] magnitude;
        // the most negative key has no positive twin and lands in bucket 0
        if (k == KEY_MIN) return 0;
        magnitude = k[FSKF_KEY_W-1] ? (~k + 1'b1) : k;
        return magnitude & (FSKF_BUCKET_COUNT - 1);
    endfunction

    // Look the key up, insert it at the chain head if absent, return the result
    function automatic t_lookup admit_key(input logic [FSKF_KEY_W-1:0] k);
        t_lookup     res;
        int unsigned bucket;
        int unsigned link;
        int unsigned hops;
        bit          found;
        bucket      = bucket_index(k);
        link        = chain_head[bucket];
        hops        = 0;
        found       = 1'b0;
        res         = '0;
        res.key_out = k;
        while (!found && link != 0 && hops < keys_stored) begin
            if (stored_key[link-1] == k) begin
                found = 1'b1;
            end else begin
                link = stored_link[link-1];
                hops++;
            end
        end
        if (!found) begin
            if (keys_stored >= FSKF_ENTRY_CAPACITY) begin
                res.store_full = 1'b1;
            end else begin
                stored_key[keys_stored]  = k;
                stored_link[keys_stored] = chain_head[bucket];
                chain_head[bucket]       = keys_stored + 1;
                res.is_new               = 1'b1;
                res.position             = FSKF_POS_W'(keys_stored);
                keys_stored++;
            end
        end
        res.unique_count = FSKF_UCNT_W'(keys_stored);
        return res;
    endfunction

    // Random key, biased toward repeats and bucket collisions
    function automatic logic [FSKF_KEY_W-1:0] pick_key();
        int unsigned           roll;
        logic [FSKF_KEY_W-1:0] base;
        roll = $urandom_range(0, 99);
        if (sent_keys.size() == 0 || roll < 30) return $urandom;
        base = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
        if (roll < 65) return base;
        if (roll < 75) return ~base + 1'b1;
        if (roll < 90) return base + ($urandom_range(1, 7) << 14);
        return EDGE_KEYS[$urandom_range(0, 7)];
    endfunction

    // Offer one key request; predict its result once it is taken
    task automatic send_key(input logic [FSKF_KEY_W-1:0] k, input bit use_typed,
                            input t_lookup typed_res);
        int      gap;
        t_lookup predicted;
        if (keys_sent % 64 == 0) send_quiet = ($urandom_range(0, 3) == 0);
        gap = send_quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tdata  <= k;
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!(i_s_axis_tvalid && o_s_axis_tready));
        predicted = admit_key(k);
        pending_results.push_back(use_typed ? typed_res : predicted);
        sent_keys.push_back(k);
        keys_sent++;
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endfunction

    // Result sink with random back-pressure and one long hold
    initial begin : result_sink
        int          gap;
        int unsigned taken;
        bit          quiet;
        t_lookup     want;
        taken = 0;
        quiet = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (taken % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
            gap = quiet ? 0 : $urandom_range(0, 6);
            if (taken == HOLD_AT) gap = HOLD_CYCLES;
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_axis_tvalid && i_m_axis_tready));
            taken++;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t ns: unexpected result, expected none, got %h",
                         $time, o_m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                check_field("key_out", want.key_out, o_m_axis_tdata[31:0]);
                check_field("is_new", want.is_new, o_m_axis_tdata[32]);
                check_field("position", want.position, o_m_axis_tdata[45:33]);
                check_field("store_full", want.store_full, o_m_axis_tdata[46]);
                check_field("unique_count", want.unique_count, o_m_axis_tdata[60:47]);
                check_field("pad", '0, o_m_axis_tdata[63:61]);
            end
        end
    end

    // Watchdog: cycles without any request moving on either side
    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) ||
                (o_m_axis_tvalid && i_m_axis_tready))
                stalled = 0;
            else
                stalled++;
        end
        $display("** first_seen_key_filter: FAILED **");
        $finish;
    end

    // Main sequence
    initial begin : key_source
        t_probe_row row;
        t_lookup    typed_res;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (PROBE_ROWS[i]) begin
            row       = PROBE_ROWS[i];
            typed_res = '{row.key, row.is_new, row.position, 1'b0, row.unique_count};
            send_key(row.key, row.typed, typed_res);
        end

        // sender pause until every pending result is back
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);

        repeat (RANDOM_KEYS) send_key(pick_key(), 1'b0, '0);

        // fill the store, then hit it while full
        while (keys_stored < FSKF_ENTRY_CAPACITY) send_key($urandom, 1'b0, '0);
        repeat (AFTER_FULL) send_key(pick_key(), 1'b0, '0);
        i_s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("** first_seen_key_filter: PASSED **");
        end else begin
            $display("** first_seen_key_filter: FAILED **");
        end
        $finish;
    end

endmodule
